FILE: hw/rtl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants of the 3x3 RGB median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int NUM_CHANNELS = 3;
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
  localparam int WIN_TAPS     = 9;

  // channel slots inside a pixel word
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // register indexes on the configuration port
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [COL_BITS:0] WIDTH_RESET  = (COL_BITS + 1)'(640);
  localparam logic [ROW_BITS:0] HEIGHT_RESET = (ROW_BITS + 1)'(480);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] pixel_t;
  typedef logic [ROW_BITS-1:0] row_t;
  typedef logic [COL_BITS-1:0] col_t;

  // per-item tag carried down the pipeline beside the median network
  typedef struct packed {
    pixel_t cur;
    row_t   row;
    col_t   col;
    logic   is_border;
    logic   has_median;
  } tag_t;

  typedef struct packed {
    pixel_t pix;
    row_t   row;
    col_t   col;
    logic   last;
  } result_t;

endpackage

FILE: hw/rtl/mf3_pix_if.sv
// ----------------------------------------------------------------------------
// mf3_pix_if
// Input pixel channel: valid/ready handshake with one RGB pixel per item.
// ----------------------------------------------------------------------------
interface mf3_pix_if;
  logic                 valid;
  logic                 ready;
  mf3_pkg::chan_t       red;
  mf3_pkg::chan_t       green;
  mf3_pkg::chan_t       blue;
  logic                 start_of_frame;

  modport source (output valid, output red, output green, output blue,
                  output start_of_frame, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input start_of_frame, output ready);
endinterface

FILE: hw/rtl/mf3_res_if.sv
// ----------------------------------------------------------------------------
// mf3_res_if
// Result channel: filtered or passed-through pixel with its image position.
// ----------------------------------------------------------------------------
interface mf3_res_if;
  logic           valid;
  logic           ready;
  mf3_pkg::chan_t out_red;
  mf3_pkg::chan_t out_green;
  mf3_pkg::chan_t out_blue;
  mf3_pkg::row_t  out_row;
  mf3_pkg::col_t  out_col;
  logic           last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_row, output out_col, output last, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input out_row, input out_col, input last, output ready);
endinterface

FILE: hw/rtl/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mf3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when both ports hit one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/mf3_sort_cell.sv
// ----------------------------------------------------------------------------
// mf3_sort_cell
// Registered three-input sorter: the building cell of the median network.
// ----------------------------------------------------------------------------
module mf3_sort_cell (
  input  logic           clk,
  input  logic           en,
  input  mf3_pkg::chan_t a,
  input  mf3_pkg::chan_t b,
  input  mf3_pkg::chan_t c,
  output mf3_pkg::chan_t lo,
  output mf3_pkg::chan_t mid,
  output mf3_pkg::chan_t hi
);

  mf3_pkg::chan_t ab_lo, ab_hi, t_lo, t_hi;

  always_comb begin
    ab_lo = (a < b) ? a : b;
    ab_hi = (a < b) ? b : a;
    t_lo  = (ab_lo < c) ? ab_lo : c;
    t_hi  = (ab_lo < c) ? c : ab_lo;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo  <= t_lo;
      mid <= (ab_hi < t_hi) ? ab_hi : t_hi;
      hi  <= (ab_hi < t_hi) ? t_hi : ab_hi;
    end
  end

endmodule

FILE: hw/rtl/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median
// Three-stage median-of-nine network per channel built from sort cells:
// sort columns, sort rows, then take the middle of the three candidates.
// ----------------------------------------------------------------------------
module mf3_median (
  input  logic            clk,
  input  logic            en,
  input  mf3_pkg::pixel_t win [mf3_pkg::WIN_TAPS],
  output mf3_pkg::pixel_t median
);

  for (genvar ch = 0; ch < mf3_pkg::NUM_CHANNELS; ch++) begin : g_chan
    mf3_pkg::chan_t col_lo [3];
    mf3_pkg::chan_t col_mid [3];
    mf3_pkg::chan_t col_hi [3];
    mf3_pkg::chan_t max_lo, med_mid, min_hi;

    for (genvar c = 0; c < 3; c++) begin : g_col
      mf3_sort_cell u_col (
        .clk (clk), .en (en),
        .a   (win[c][ch]), .b (win[3 + c][ch]), .c (win[6 + c][ch]),
        .lo  (col_lo[c]), .mid (col_mid[c]), .hi (col_hi[c])
      );
    end

    // keep only the candidate each row can still contribute
    mf3_sort_cell u_row_lo (
      .clk (clk), .en (en),
      .a (col_lo[0]), .b (col_lo[1]), .c (col_lo[2]),
      .lo (), .mid (), .hi (max_lo)
    );
    mf3_sort_cell u_row_mid (
      .clk (clk), .en (en),
      .a (col_mid[0]), .b (col_mid[1]), .c (col_mid[2]),
      .lo (), .mid (med_mid), .hi ()
    );
    mf3_sort_cell u_row_hi (
      .clk (clk), .en (en),
      .a (col_hi[0]), .b (col_hi[1]), .c (col_hi[2]),
      .lo (min_hi), .mid (), .hi ()
    );

    mf3_sort_cell u_final (
      .clk (clk), .en (en),
      .a (max_lo), .b (med_mid), .c (min_hi),
      .lo (), .mid (median[ch]), .hi ()
    );
  end

endmodule

FILE: hw/rtl/median_filter_3x3_rgb_core.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb_core
// Raster-order RGB 3x3 median filter with two line stores, a sliding window,
// a chain of sort cells and a small result queue.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while the result queue has room; a pixel
//   with both a border and a median result puts two results on the single
//   result port. A pixel passes the line-store read, the window, three
//   sort-cell stages and the result queue on its way to the output.
// Reset: counters to zero, size registers to 640 x 480, queue empty; the line
//   stores are not cleared.
module median_filter_3x3_rgb_core (
  input  logic        clk,
  input  logic        rst,
  mf3_pix_if.sink     pix,
  mf3_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PIX_BITS = $bits(mf3_pkg::pixel_t);

  // --------------------------------------------------------------------------
  // configuration registers
  logic [mf3_pkg::COL_BITS:0] image_width;
  logic [mf3_pkg::ROW_BITS:0] image_height;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mf3_pkg::WIDTH_RESET;
      image_height <= mf3_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        mf3_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[mf3_pkg::COL_BITS:0];
        mf3_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[mf3_pkg::ROW_BITS:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mf3_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      mf3_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:                   prdata = '0;
    endcase
  end

  // clamp sizes to 1..max
  logic [mf3_pkg::COL_BITS:0] eff_width;
  logic [mf3_pkg::ROW_BITS:0] eff_height;

  always_comb begin
    if (image_width == '0) begin
      eff_width = (mf3_pkg::COL_BITS + 1)'(1);
    end else if (image_width > (mf3_pkg::COL_BITS + 1)'(mf3_pkg::MAX_WIDTH)) begin
      eff_width = (mf3_pkg::COL_BITS + 1)'(mf3_pkg::MAX_WIDTH);
    end else begin
      eff_width = image_width;
    end
    if (image_height == '0) begin
      eff_height = (mf3_pkg::ROW_BITS + 1)'(1);
    end else if (image_height > (mf3_pkg::ROW_BITS + 1)'(mf3_pkg::MAX_HEIGHT)) begin
      eff_height = (mf3_pkg::ROW_BITS + 1)'(mf3_pkg::MAX_HEIGHT);
    end else begin
      eff_height = image_height;
    end
  end

  // --------------------------------------------------------------------------
  // handshake and position counters
  logic [mf3_pkg::FIFO_CNT_BITS-1:0] count;
  logic                              advance;
  logic                              accept;

  assign advance   = count <= mf3_pkg::FIFO_CNT_BITS'(mf3_pkg::FIFO_DEPTH - 2);
  assign pix.ready = advance;
  assign accept    = pix.valid & advance;

  mf3_pkg::row_t               row_count, row_count_next, cur_row;
  mf3_pkg::col_t               col_count, col_count_next, cur_col;
  logic [mf3_pkg::ROW_BITS:0]  row_inc;
  logic [mf3_pkg::COL_BITS:0]  col_inc;
  mf3_pkg::tag_t               in_tag;

  always_comb begin
    cur_row = pix.start_of_frame ? '0 : row_count;
    cur_col = pix.start_of_frame ? '0 : col_count;
    row_inc = {1'b0, cur_row} + (mf3_pkg::ROW_BITS + 1)'(1);
    col_inc = {1'b0, cur_col} + (mf3_pkg::COL_BITS + 1)'(1);

    in_tag.cur[mf3_pkg::CH_RED]   = pix.red;
    in_tag.cur[mf3_pkg::CH_GREEN] = pix.green;
    in_tag.cur[mf3_pkg::CH_BLUE]  = pix.blue;
    in_tag.row        = cur_row;
    in_tag.col        = cur_col;
    in_tag.is_border  = (cur_row == '0) || (cur_col == '0) ||
                        (row_inc >= eff_height) || (col_inc >= eff_width);
    in_tag.has_median = (cur_row >= mf3_pkg::ROW_BITS'(2)) &&
                        (cur_col >= mf3_pkg::COL_BITS'(2));

    // wrap column, then row
    if (col_inc >= eff_width) begin
      col_count_next = '0;
      row_count_next = (row_inc >= eff_height) ? '0 : row_inc[mf3_pkg::ROW_BITS-1:0];
    end else begin
      col_count_next = col_inc[mf3_pkg::COL_BITS-1:0];
      row_count_next = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // tag pipeline, aligned with line-store read, window and the sort stages
  mf3_pkg::tag_t tag_q [5];
  logic [4:0]    vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[3:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag_q[0] <= in_tag;
      for (int i = 1; i < 5; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // line stores
  mf3_pkg::pixel_t mid_q, upper_q, upper_pix, fwd_data;
  logic            upper_we;
  logic            fwd_hit;

  assign upper_we = advance & vld[0];

  mf3_ram #(.WIDTH(PIX_BITS), .DEPTH(mf3_pkg::MAX_WIDTH)) u_line_middle (
    .clk   (clk),
    .we    (accept),
    .waddr (cur_col),
    .wdata (in_tag.cur),
    .re    (accept),
    .raddr (cur_col),
    .rdata (mid_q)
  );

  mf3_ram #(.WIDTH(PIX_BITS), .DEPTH(mf3_pkg::MAX_WIDTH)) u_line_upper (
    .clk   (clk),
    .we    (upper_we),
    .waddr (tag_q[0].col),
    .wdata (mid_q),
    .re    (accept),
    .raddr (cur_col),
    .rdata (upper_q)
  );

  // bypass an upper-store write that lands on the address read at this edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (accept) begin
      fwd_hit <= upper_we && (tag_q[0].col == cur_col);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= mid_q;
    end
  end

  assign upper_pix = fwd_hit ? fwd_data : upper_q;

  // --------------------------------------------------------------------------
  // 3x3 window: rows upper, middle, current; column 2 is the newest
  mf3_pkg::pixel_t win [mf3_pkg::WIN_TAPS];

  always_ff @(posedge clk) begin
    if (upper_we) begin
      for (int r = 0; r < 3; r++) begin
        win[3*r]     <= win[3*r + 1];
        win[3*r + 1] <= win[3*r + 2];
      end
      win[2] <= upper_pix;
      win[5] <= mid_q;
      win[8] <= tag_q[0].cur;
    end
  end

  mf3_pkg::pixel_t median;

  mf3_median u_median (
    .clk    (clk),
    .en     (advance),
    .win    (win),
    .median (median)
  );

  // --------------------------------------------------------------------------
  // result queue
  mf3_pkg::result_t                  fifo_mem [mf3_pkg::FIFO_DEPTH];
  logic [mf3_pkg::FIFO_PTR_BITS-1:0] wr_ptr, rd_ptr;
  mf3_pkg::result_t                  border_res, med_res, first_res;
  logic [1:0]                        n_push;
  logic                              pop;

  always_comb begin
    border_res.pix  = tag_q[4].cur;
    border_res.row  = tag_q[4].row;
    border_res.col  = tag_q[4].col;
    border_res.last = !tag_q[4].has_median;
    med_res.pix     = median;
    med_res.row     = tag_q[4].row - mf3_pkg::ROW_BITS'(1);
    med_res.col     = tag_q[4].col - mf3_pkg::COL_BITS'(1);
    med_res.last    = 1'b1;
    first_res       = tag_q[4].is_border ? border_res : med_res;
    if (advance && vld[4]) begin
      n_push = 2'(tag_q[4].is_border) + 2'(tag_q[4].has_median);
    end else begin
      n_push = '0;
    end
  end

  assign pop = res.valid & res.ready;

  always_ff @(posedge clk) begin
    if (n_push != '0) begin
      fifo_mem[wr_ptr] <= first_res;
    end
    if (n_push == 2'd2) begin
      fifo_mem[wr_ptr + mf3_pkg::FIFO_PTR_BITS'(1)] <= med_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + mf3_pkg::FIFO_PTR_BITS'(n_push);
      rd_ptr <= rd_ptr + mf3_pkg::FIFO_PTR_BITS'(pop);
      count  <= count + mf3_pkg::FIFO_CNT_BITS'(n_push) - mf3_pkg::FIFO_CNT_BITS'(pop);
    end
  end

  assign res.valid     = count != '0;
  assign res.out_red   = fifo_mem[rd_ptr].pix[mf3_pkg::CH_RED];
  assign res.out_green = fifo_mem[rd_ptr].pix[mf3_pkg::CH_GREEN];
  assign res.out_blue  = fifo_mem[rd_ptr].pix[mf3_pkg::CH_BLUE];
  assign res.out_row   = fifo_mem[rd_ptr].row;
  assign res.out_col   = fifo_mem[rd_ptr].col;
  assign res.last      = fifo_mem[rd_ptr].last;

  // --------------------------------------------------------------------------
  // assertions
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    count <= mf3_pkg::FIFO_CNT_BITS'(mf3_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_window_follows: assert property (@(posedge clk) disable iff (rst)
    advance && vld[0] |=> vld[1])
    else $error("item lost between line-store read and window");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && pix.start_of_frame |=>
      (col_count <= mf3_pkg::COL_BITS'(1)) && (row_count <= mf3_pkg::ROW_BITS'(1)))
    else $error("position counters not restarted on start of frame");

endmodule

FILE: bench/mf3_median_check.sv
// ----------------------------------------------------------------------------
// mf3_median_check
// Watches the pixel, result and register ports of the 3x3 RGB median filter,
// keeps its own copy of the line stores, window and position counters, and
// compares every result pixel against the predicted one, field by field.
// ----------------------------------------------------------------------------
module mf3_median_check
  import mf3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mf3_pix_if          pix,
  mf3_res_if          res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          due_count,
  output int          mismatches
);

  pixel_t            upper_line  [MAX_WIDTH];
  pixel_t            middle_line [MAX_WIDTH];
  pixel_t            win [3][3];
  int                row_pos;
  int                col_pos;
  logic [COL_BITS:0] width_reg;
  logic [ROW_BITS:0] height_reg;
  result_t           pixels_due [$];
  int                fail_count = 0;

  initial begin
    due_count  = 0;
    mismatches = 0;
  end

  // median is the value with at most four taps below it and at least five at or below
  function automatic chan_t median_of_nine(input chan_t taps [9]);
    int below;
    int at_most;
    for (int i = 0; i < 9; i++) begin
      below   = 0;
      at_most = 0;
      for (int k = 0; k < 9; k++) begin
        if (taps[k] < taps[i]) below++;
        if (taps[k] <= taps[i]) at_most++;
      end
      if (below <= 4 && at_most >= 5) return taps[i];
    end
    return taps[0];
  endfunction

  task automatic filter_pixel(input chan_t r, input chan_t g, input chan_t b,
                              input logic sof);
    int      ew;
    int      eh;
    int      row;
    int      col;
    bit      on_edge;
    bit      has_median;
    pixel_t  cur;
    pixel_t  up;
    pixel_t  mid;
    pixel_t  med;
    chan_t   taps [9];
    result_t item;

    ew = (width_reg == 0) ? 1 : int'(width_reg);
    if (ew > MAX_WIDTH) ew = MAX_WIDTH;
    eh = (height_reg == 0) ? 1 : int'(height_reg);
    if (eh > MAX_HEIGHT) eh = MAX_HEIGHT;

    if (sof) begin
      row_pos = 0;
      col_pos = 0;
    end
    row = row_pos;
    col = (col_pos >= MAX_WIDTH) ? 0 : col_pos;

    cur[CH_RED]   = r;
    cur[CH_GREEN] = g;
    cur[CH_BLUE]  = b;

    up  = upper_line[col];
    mid = middle_line[col];
    upper_line[col]  = mid;
    middle_line[col] = cur;

    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = cur;

    on_edge    = (row == 0 || col == 0 || row + 1 >= eh || col + 1 >= ew);
    has_median = (row >= 2 && col >= 2);

    // border pixel goes out first, the median of the center one back second
    if (on_edge) begin
      item.pix  = cur;
      item.row  = row_t'(row);
      item.col  = col_t'(col);
      item.last = !has_median;
      pixels_due.push_back(item);
    end
    if (has_median) begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        for (int k = 0; k < 9; k++) taps[k] = win[k / 3][k % 3][ch];
        med[ch] = median_of_nine(taps);
      end
      item.pix  = med;
      item.row  = row_t'(row - 1);
      item.col  = col_t'(col - 1);
      item.last = 1'b1;
      pixels_due.push_back(item);
    end

    col++;
    if (col >= ew) begin
      col = 0;
      row++;
      if (row >= eh) row = 0;
    end
    row_pos = row;
    col_pos = col;
  endtask

  task automatic check_result();
    result_t want;
    if (pixels_due.size() == 0) begin
      $error("result with nothing due: row %0d col %0d", res.out_row, res.out_col);
      fail_count++;
    end else begin
      want = pixels_due.pop_front();
      if (res.out_red !== want.pix[CH_RED]) begin
        $error("out_red: expected %0d, actual %0d", want.pix[CH_RED], res.out_red);
        fail_count++;
      end
      if (res.out_green !== want.pix[CH_GREEN]) begin
        $error("out_green: expected %0d, actual %0d", want.pix[CH_GREEN], res.out_green);
        fail_count++;
      end
      if (res.out_blue !== want.pix[CH_BLUE]) begin
        $error("out_blue: expected %0d, actual %0d", want.pix[CH_BLUE], res.out_blue);
        fail_count++;
      end
      if (res.out_row !== want.row) begin
        $error("out_row: expected %0d, actual %0d", want.row, res.out_row);
        fail_count++;
      end
      if (res.out_col !== want.col) begin
        $error("out_col: expected %0d, actual %0d", want.col, res.out_col);
        fail_count++;
      end
      if (res.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, res.last);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++) win[i][k] = '0;
      pixels_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_IMAGE_WIDTH) width_reg = pwdata[COL_BITS:0];
        else height_reg = pwdata[ROW_BITS:0];
      end
      if (pix.valid && pix.ready)
        filter_pixel(pix.red, pix.green, pix.blue, pix.start_of_frame);
      if (res.valid && res.ready) check_result();
    end
    // publish after the edge so the stimulus side reads settled counts
    due_count  <= pixels_due.size();
    mismatches <= fail_count;
  end

endmodule

FILE: bench/median_filter_3x3_rgb_core_tb.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb_core_tb
// Drives pixel frames of many sizes through the 3x3 RGB median filter, with
// random idle cycles on both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module median_filter_3x3_rgb_core_tb;
  import mf3_pkg::*;

  localparam int IDLE_PCT    = 29;
  localparam int DRAIN       = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_ITEMS  = 500;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        sink_ready = 1'b0;
  logic        calm       = 1'b0;
  int          due_count;
  int          mismatches;
  int          quiet      = 0;
  int          eff_w      = 640;
  int          eff_h      = 480;
  int          frame_pos  = 0;

  mf3_pix_if pix_ch ();
  mf3_res_if res_ch ();

  assign res_ch.ready = sink_ready;

  median_filter_3x3_rgb_core DUT (
    .clk     (clk),
    .rst     (rst),
    .pix     (pix_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mf3_median_check checker_i (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix_ch),
    .res        (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .due_count  (due_count),
    .mismatches (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    sink_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("median_filter_3x3_rgb_core_tb failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_size(input int w, input int h);
    write_reg({REG_IMAGE_WIDTH, 2'b00}, 32'(w));
    write_reg({REG_IMAGE_HEIGHT, 2'b00}, 32'(h));
    eff_w = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    eff_h = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
  endtask

  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b,
                            input logic sof);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        pix_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    pix_ch.valid          <= 1'b1;
    pix_ch.red            <= r;
    pix_ch.green          <= g;
    pix_ch.blue           <= b;
    pix_ch.start_of_frame <= sof;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    frame_pos = sof ? 1 : frame_pos + 1;
    if (frame_pos >= eff_w * eff_h) frame_pos = 0;
  endtask

  // open with a frame start, then mostly whole frames with rare restarts
  task automatic send_frames(input int count);
    logic sof;
    for (int n = 0; n < count; n++) begin
      if (n == 0) sof = 1'b1;
      else if (frame_pos == 0) sof = 1'($urandom_range(0, 1));
      else sof = ($urandom_range(0, 99) < 2);
      send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), sof);
    end
  endtask

  // wait until every expected result is out, then let the pipeline drain
  task automatic settle();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    int rand_count;
    int w;
    int h;
    int count;
    int kind;

    pix_ch.valid          <= 1'b0;
    pix_ch.red            <= '0;
    pix_ch.green          <= '0;
    pix_ch.blue           <= '0;
    pix_ch.start_of_frame <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset size: a few border pixels with channel extremes
    send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    settle();

    // shrink below the current column: next pixel is a border, then wrap
    set_size(4, 4);
    for (int i = 0; i < 13; i++)
      send_pixel(8'(i * 20), 8'(255 - i * 19), (i % 3 == 0) ? 8'd255 : 8'(i * 7), 1'b0);
    settle();

    // zero sizes act as one pixel per frame
    set_size(0, 0);
    send_pixel(8'd128, 8'd1, 8'd254, 1'b0);
    send_pixel(8'd127, 8'd254, 8'd1, 1'b1);
    settle();

    // saturated width: walk the whole row and wrap
    calm <= 1'b1;
    set_size(2047, 0);
    send_frames(MAX_WIDTH + 6);
    settle();
    calm <= 1'b0;
    set_size(0, 8191);
    send_frames(40);
    settle();
    set_size(MAX_WIDTH, MAX_HEIGHT);
    send_frames(40);
    settle();

    rand_count = 0;
    while (rand_count < RAND_ITEMS) begin
      calm <= ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        w = $urandom_range(0, 2);
        h = $urandom_range(0, 4);
      end else if (kind == 1) begin
        w = $urandom_range(MAX_WIDTH, 2047);
        h = $urandom_range(0, 3);
      end else if (kind == 2) begin
        w = $urandom_range(0, 3);
        h = $urandom_range(MAX_HEIGHT, 8191);
      end else begin
        w = $urandom_range(3, 9);
        h = $urandom_range(3, 6);
      end
      set_size(w, h);
      if (kind == 0) count = 12;
      else if (kind <= 2) count = 40;
      else begin
        count = eff_w * eff_h * $urandom_range(1, 2);
        // cut the last frame short now and then
        if ($urandom_range(0, 3) == 0) count += $urandom_range(1, eff_w * 2);
      end
      send_frames(count);
      rand_count += count;
      settle();
    end

    if (mismatches == 0) begin
      $display("median_filter_3x3_rgb_core_tb passed");
    end else begin
      $display("median_filter_3x3_rgb_core_tb failed");
    end
    $finish;
  end

endmodule
